### rtl/timed_reply_frame_responder_top_macros.svh
// Assertion macros shared by the timed reply frame responder.
`ifndef TIMED_REPLY_FRAME_RESPONDER_TOP_MACROS_SVH
`define TIMED_REPLY_FRAME_RESPONDER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TRFR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("responder same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define TRFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("responder next-cycle check failed");

`endif

### rtl/trfr_pkg.sv
// Shared constants, command and status types, and the reply ROM of the responder.
package trfr_pkg;

    localparam int FRAME_BYTES_DEF = 42;
    localparam int MAX_CHUNK_DEF   = 32;
    localparam int DELAY_SLOTS_DEF = 10;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] END_BYTE   = 8'hE7;
    localparam logic [7:0] LEN_MARK   = 8'd43;

    // Emission limits and ROM layout.
    localparam int MAX_OUT     = 32;
    localparam int ROM_LEN     = 96;
    localparam int LEN_W       = 7;
    localparam int CNT_W       = 6;
    localparam int SLOT_W      = 4;
    localparam int ROM_IDX_W   = 8;

    localparam logic [ROM_IDX_W-1:0] HEADER_POS  = 8'd0;
    localparam logic [LEN_W-1:0]     HEADER_LEN  = 7'd2;
    localparam logic [ROM_IDX_W-1:0] FIRST_POS   = 8'd2;
    localparam logic [ROM_IDX_W-1:0] TRAILER_POS = 8'd13;
    localparam logic [LEN_W-1:0]     TRAILER_LEN = 7'd3;

    typedef logic [ROM_IDX_W-1:0] rom_idx_t;

    typedef struct packed {
        logic                 timer_inc;
        logic                 timer_clear;
        logic                 clen_load;
        logic                 pos_clear;
        logic                 data_write;
        logic                 rd_req;
        logic [SLOT_W-1:0]    rd_slot;
        logic                 emit_start;
        logic                 emit_use_clen;
        rom_idx_t             emit_pos;
        logic [LEN_W-1:0]     emit_len;
    } trfr_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic timer_ge;
        logic emit_busy;
        logic emit_done;
    } trfr_sts_t;

    localparam logic [7:0] REPLY_ROM [ROM_LEN] = '{
        8'h7E, 8'h0D, 8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52,
        8'h6F, 8'h61, 8'h6E, 8'h6C, 8'h0D, 8'h01, 8'h02, 8'hE7,
        8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52, 8'h6F, 8'h61, 8'h6E, 8'h6C,
        8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52, 8'h6F, 8'h61, 8'h6E, 8'h6C,
        8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52, 8'h6F, 8'h61, 8'h6E, 8'h6C,
        8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52, 8'h6F, 8'h61, 8'h6E, 8'h6C,
        8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52, 8'h6F, 8'h61, 8'h6E, 8'h6C,
        8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52, 8'h6F, 8'h61, 8'h6E, 8'h6C,
        8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52, 8'h6F, 8'h61, 8'h6E, 8'h6C,
        8'h2E, 8'h74, 8'h69, 8'h65, 8'h35, 8'h52, 8'h6F, 8'h61, 8'h6E, 8'h6C
    };

    // Addresses past the end of the ROM read as zero.
    function automatic logic [7:0] rom_byte(input rom_idx_t idx);
        logic [7:0] b;
        b = (idx < ROM_IDX_W'(ROM_LEN)) ? REPLY_ROM[idx[6:0]] : 8'h00;
        return b;
    endfunction

endpackage

### rtl/trfr_ifs.sv
// Valid/ready channel interfaces for request words and reply words.
interface trfr_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface trfr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       chunk_last;

    modport source (output valid, output tx_byte, output chunk_last, input ready);
    modport sink   (input valid, input tx_byte, input chunk_last, output ready);
endinterface

### rtl/timed_reply_frame_responder_top.sv
// Top level of the timed reply frame responder: controller, datapath and checks.
//
// The req channel carries one word per received byte (func = 0) or per 10 us tick
// (func = 1). The rsp channel carries the reply, one ROM byte per word, with
// chunk_last set on the final byte of the chunk sent by one tick.
// A received byte leaves req.ready high, so bytes stream in back to back at link speed.
// A tick that sends nothing leaves req.ready high, but one that waits on a delay slot drops it in S_CHECK.
// A tick that sends a chunk of n bytes (n at most 32) holds req.ready low until
// the last byte is loaded into the output register. A timed chunk first has its
// delay word read from the frame store and then compared with the timer in
// S_CHECK. Every cycle in which rsp.ready stays low stretches this, since the
// single output register holds its word until it is taken.
// A finished word waiting in the output register does not block the next req word.
// Reset clears the parser, the reply step, the timer and the output valid flag.
// The frame store is not cleared and needs no clearing pass; the parser writes
// every delay slot before a delay is read.
module timed_reply_frame_responder_top
    import trfr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MAX_CHUNK   = MAX_CHUNK_DEF,
    parameter int DELAY_SLOTS = DELAY_SLOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    trfr_req_if.sink   req,
    trfr_rsp_if.source rsp
);

    `include "timed_reply_frame_responder_top_macros.svh"

    trfr_cmd_t cmd;
    trfr_sts_t sts;
    logic      accept;

    // A word is taken whenever the controller is ready and the sender is valid.
    assign accept = req.valid && req.ready;

    trfr_ctrl #(
        .MAX_CHUNK   (MAX_CHUNK),
        .DELAY_SLOTS (DELAY_SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .func     (req.func),
        .rx_byte  (req.rx_byte),
        .sts      (sts),
        .in_ready (req.ready),
        .cmd      (cmd)
    );

    trfr_dp #(
        .FRAME_BYTES (FRAME_BYTES),
        .MAX_CHUNK   (MAX_CHUNK)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rx_byte    (req.rx_byte),
        .out_ready  (rsp.ready),
        .sts        (sts),
        .out_valid  (rsp.valid),
        .tx_byte    (rsp.tx_byte),
        .chunk_last (rsp.chunk_last)
    );

    // While a chunk streams out, no request word may be taken.
    `TRFR_ASSERT_SAME(a_emit_blocks_req, sts.emit_busy, !req.ready)
    // A started chunk is streaming in the next cycle.
    `TRFR_ASSERT_NEXT(a_start_sets_busy, cmd.emit_start, sts.emit_busy)
    // The last byte loaded ends the chunk.
    `TRFR_ASSERT_NEXT(a_done_clears_busy, sts.emit_done, !sts.emit_busy)
    // A received byte never starts a reply chunk.
    `TRFR_ASSERT_NEXT(a_byte_no_emit, accept && !req.func, !sts.emit_busy)

endmodule

### rtl/trfr_ctrl.sv
// Controller: request parser phase, reply step sequencing and word handshake.
module trfr_ctrl
    import trfr_pkg::*;
#(
    parameter int MAX_CHUNK   = MAX_CHUNK_DEF,
    parameter int DELAY_SLOTS = DELAY_SLOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       func,
    input  logic [7:0] rx_byte,
    input  trfr_sts_t  sts,
    output logic       in_ready,
    output trfr_cmd_t  cmd
);

    localparam int SW = $clog2(DELAY_SLOTS + 3);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_CLEN,
        PH_DATA,
        PH_END,
        PH_REPLY
    } phase_t;

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [SW-1:0]   step_reg, step_next;
    logic            ready_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !func)
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (rx_byte == START_BYTE)
                            begin
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            phase_next = (rx_byte == LEN_MARK) ? PH_CLEN : PH_HUNT;
                        end
                        PH_CLEN:
                        begin
                            if ((rx_byte >= 8'd1) && (rx_byte <= 8'(MAX_CHUNK)))
                            begin
                                cmd.clen_load = 1'b1;
                                cmd.pos_clear = 1'b1;
                                phase_next    = PH_DATA;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_DATA:
                        begin
                            cmd.data_write = 1'b1;
                            if (sts.pos_last)
                            begin
                                phase_next = PH_END;
                            end
                        end
                        PH_END:
                        begin
                            if (rx_byte == END_BYTE)
                            begin
                                step_next  = '0;
                                phase_next = PH_REPLY;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_REPLY:
                        begin
                            phase_next = PH_REPLY;
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
                else if (accept && func)
                begin
                    cmd.timer_inc = 1'b1;
                    if (phase_reg == PH_REPLY)
                    begin
                        if (step_reg == SW'(0))
                        begin
                            step_next      = SW'(1);
                            cmd.emit_start = 1'b1;
                            cmd.emit_pos   = HEADER_POS;
                            cmd.emit_len   = HEADER_LEN;
                            state_next     = S_EMIT;
                        end
                        else if (step_reg == SW'(1))
                        begin
                            step_next         = SW'(2);
                            cmd.timer_clear   = 1'b1;
                            cmd.emit_start    = 1'b1;
                            cmd.emit_use_clen = 1'b1;
                            cmd.emit_pos      = FIRST_POS;
                            state_next        = S_EMIT;
                        end
                        else if (step_reg < SW'(DELAY_SLOTS + 2))
                        begin
                            cmd.rd_req  = 1'b1;
                            cmd.rd_slot = SLOT_W'(step_reg - SW'(2));
                            state_next  = S_CHECK;
                        end
                        else
                        begin
                            step_next  = '0;
                            phase_next = PH_HUNT;
                            if (step_reg == SW'(DELAY_SLOTS + 2))
                            begin
                                cmd.emit_start = 1'b1;
                                cmd.emit_pos   = TRAILER_POS;
                                cmd.emit_len   = TRAILER_LEN;
                                state_next     = S_EMIT;
                            end
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.timer_ge)
                begin
                    step_next         = step_reg + SW'(1);
                    cmd.timer_clear   = 1'b1;
                    cmd.emit_start    = 1'b1;
                    cmd.emit_use_clen = 1'b1;
                    cmd.emit_pos      = ROM_IDX_W'(step_reg) + ROM_IDX_W'(1);
                    state_next        = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_HUNT;
            step_reg  <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

### rtl/trfr_dp.sv
// Datapath: frame store, tick timer, chunk length and reply byte streamer.
module trfr_dp
    import trfr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MAX_CHUNK   = MAX_CHUNK_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  trfr_cmd_t  cmd,
    input  logic [7:0] rx_byte,
    input  logic       out_ready,
    output trfr_sts_t  sts,
    output logic       out_valid,
    output logic [7:0] tx_byte,
    output logic       chunk_last
);

    localparam int WORDS      = (FRAME_BYTES + 3) / 4;
    localparam int NUM_DELAYS = FRAME_BYTES / 4;
    localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW         = ($clog2(FRAME_BYTES) > 2) ? $clog2(FRAME_BYTES) : 2;
    localparam int CW         = $clog2(MAX_CHUNK + 1);
    localparam int IW         = CNT_W - 1;

    // Frame store, one little-endian delay word per row.
    logic [3:0][7:0]      frame_mem [WORDS];

    logic [PW-1:0]        pos_reg;
    logic [CW-1:0]        clen_reg;
    logic [31:0]          timer_reg;
    logic [31:0]          rdata_reg;
    logic                 slot_ok_reg;

    logic                 emit_busy_reg;
    rom_idx_t             emit_pos_reg;
    logic [IW-1:0]        emit_idx_reg;
    logic [CNT_W-1:0]     emit_n_reg;

    logic                 out_valid_reg;
    logic [7:0]           tx_byte_reg;
    logic                 chunk_last_reg;

    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic                 slot_ok;
    logic [LEN_W-1:0]     emit_len;
    logic [CNT_W-1:0]     emit_n;
    logic                 load;
    logic                 last;
    logic [31:0]          delay;

    assign waddr   = AW'(pos_reg >> 2);
    assign slot_ok = (32'(cmd.rd_slot) < NUM_DELAYS);
    assign raddr   = slot_ok ? AW'(cmd.rd_slot) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.data_write)
        begin
            frame_mem[waddr][pos_reg[1:0]] <= rx_byte;
        end
        if (cmd.rd_req)
        begin
            rdata_reg   <= frame_mem[raddr];
            slot_ok_reg <= slot_ok;
        end
    end

    assign delay        = slot_ok_reg ? rdata_reg : 32'd0;
    assign sts.timer_ge = (timer_reg >= delay);
    assign sts.pos_last = (pos_reg == PW'(FRAME_BYTES - 1));

    assign emit_len = cmd.emit_use_clen ? LEN_W'(clen_reg) : cmd.emit_len;
    assign emit_n   = (emit_len > LEN_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : CNT_W'(emit_len);
    assign load     = emit_busy_reg && (!out_valid_reg || out_ready);
    assign last     = ((CNT_W'(emit_idx_reg) + CNT_W'(1)) == emit_n_reg);

    assign sts.emit_busy = emit_busy_reg;
    assign sts.emit_done = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            clen_reg      <= '0;
            timer_reg     <= '0;
            emit_busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.pos_clear)
            begin
                pos_reg <= '0;
            end
            else if (cmd.data_write)
            begin
                pos_reg <= pos_reg + PW'(1);
            end

            if (cmd.clen_load)
            begin
                clen_reg <= CW'(rx_byte);
            end

            // The timer saturates; a clear wins over the increment of the same tick.
            if (cmd.timer_clear)
            begin
                timer_reg <= '0;
            end
            else if (cmd.timer_inc && (timer_reg != 32'hFFFF_FFFF))
            begin
                timer_reg <= timer_reg + 32'd1;
            end

            if (cmd.emit_start)
            begin
                emit_busy_reg <= 1'b1;
            end
            else if (load && last)
            begin
                emit_busy_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_start)
        begin
            emit_pos_reg <= cmd.emit_pos;
            emit_idx_reg <= '0;
            emit_n_reg   <= emit_n;
        end
        else if (load)
        begin
            emit_idx_reg <= emit_idx_reg + IW'(1);
        end
        if (load)
        begin
            tx_byte_reg    <= rom_byte(emit_pos_reg + ROM_IDX_W'(emit_idx_reg));
            chunk_last_reg <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign chunk_last = chunk_last_reg;

endmodule

### dv/tb_timed_reply_frame_responder_top.sv
// Self-checking testbench of the timed reply frame responder: directed table, random frames.
module tb_timed_reply_frame_responder_top;
    import trfr_pkg::*;

    // Values of the func field of a request word.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // A table row whose expected reply is left to the predictor.
    localparam int NO_TYPED = -1;

    // Start no new random round once this many request words have been sent.
    localparam int RANDOM_ITEMS = 60;

    // Cycles to linger once the expectation store has drained.
    localparam int DRAIN_CYCLES = 200;

    // Watchdog, far beyond the slowest legal run.
    localparam longint WATCHDOG_TIME = 64'd16_000_000;

    // Frame layout: start, mark, length, stored bytes, end byte.
    localparam int FRAME_WORDS = FRAME_BYTES_DEF + 4;
    localparam int END_POS = FRAME_WORDS - 1;

    typedef enum logic [2:0] {
        SEEK_START,
        SEEK_MARK,
        SEEK_LEN,
        TAKE_DATA,
        SEEK_END,
        REPLYING
    } rx_state_e;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       chunk_last;
    } reply_word_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_FRAME,
        ROW_TICKS
    } row_kind_e;

    // One row of the directed table. A frame row sends a whole request with the
    // chunk length in data, the end byte in aux and every delay set to count.
    typedef struct {
        row_kind_e  kind;
        logic       func;
        logic [7:0] data;
        logic [7:0] aux;
        int         count;
        int         n_exp;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
    } stim_row_t;

    logic clk;
    logic rst_n;

    trfr_req_if req_ch ();
    trfr_rsp_if rsp_ch ();

    timed_reply_frame_responder_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Predictor state: the testbench's own image of the parser, frame store,
    // reply sequencer and tick timer.
    rx_state_e   rx_state;
    int          frame_pos;
    logic [5:0]  chunk_len;
    logic [7:0]  frame_mem [FRAME_BYTES_DEF];
    logic [3:0]  reply_step;
    logic [31:0] tick_count;

    // Reply words caused by the most recent request word, and the store of
    // reply words still to be seen on the rsp channel, oldest first.
    reply_word_t step_words [$];
    reply_word_t pending_reply [$];

    stim_row_t dir_rows [$];

    int  mismatch_count;
    int  items_sent;
    bit  src_quiet;
    bit  sink_quiet;
    int  stall_left;

    // The reply ROM: header, the chunk text, 0x0D, the trailer, then eight more copies of the chunk text.
    function automatic logic [7:0] reply_rom_byte(input int idx);
        string pat;
        pat = ".tie5Roanl";
        if (idx == 0)
            return START_BYTE;
        if (idx == 1 || idx == 12)
            return 8'h0D;
        if (idx >= 2 && idx <= 11)
            return pat[idx - 2];
        if (idx == 13)
            return 8'h01;
        if (idx == 14)
            return 8'h02;
        if (idx == 15)
            return END_BYTE;
        if (idx >= 16 && idx < ROM_LEN)
            return pat[(idx - 16) % 10];
        return 8'h00;
    endfunction

    // Little-endian delay of one slot; a slot past the frame store reads as zero.
    function automatic logic [31:0] slot_delay(input int slot);
        int base;
        base = slot * 4;
        if (base + 3 >= FRAME_BYTES_DEF)
            return 32'h0;
        return {frame_mem[base + 3], frame_mem[base + 2], frame_mem[base + 1], frame_mem[base]};
    endfunction

    // Queue a run of ROM bytes as reply words, capped at the emission limit.
    task automatic queue_rom_run(input int start, input int len);
        int n;
        reply_word_t w;
        n = (len > MAX_OUT) ? MAX_OUT : len;
        for (int i = 0; i < n; i++)
        begin
            w.tx_byte = reply_rom_byte(start + i);
            w.chunk_last = (i == n - 1);
            step_words.push_back(w);
        end
    endtask

    // Advance the predictor by one accepted request word and leave the reply
    // words it causes in step_words.
    task automatic track_responder(input logic func, input logic [7:0] data);
        logic [3:0] s;
        step_words.delete();
        if (func == FUNC_BYTE)
        begin
            case (rx_state)
                SEEK_START:
                    if (data == START_BYTE)
                        rx_state = SEEK_MARK;
                SEEK_MARK:
                    rx_state = (data == LEN_MARK) ? SEEK_LEN : SEEK_START;
                SEEK_LEN:
                    if (data >= 8'd1 && data <= 8'(MAX_CHUNK_DEF))
                    begin
                        chunk_len = data[5:0];
                        frame_pos = 0;
                        rx_state = TAKE_DATA;
                    end
                    else
                        rx_state = SEEK_START;
                TAKE_DATA:
                begin
                    if (frame_pos < FRAME_BYTES_DEF)
                        frame_mem[frame_pos] = data;
                    frame_pos++;
                    if (frame_pos >= FRAME_BYTES_DEF)
                        rx_state = SEEK_END;
                end
                SEEK_END:
                    if (data == END_BYTE)
                    begin
                        reply_step = 4'd0;
                        rx_state = REPLYING;
                    end
                    else
                        rx_state = SEEK_START;
                REPLYING:
                    ;
                default:
                    rx_state = SEEK_START;
            endcase
        end
        else
        begin
            if (tick_count != 32'hFFFF_FFFF)
                tick_count++;
            if (rx_state == REPLYING)
            begin
                s = reply_step;
                if (s == 4'd0)
                begin
                    reply_step = 4'd1;
                    queue_rom_run(HEADER_POS, HEADER_LEN);
                end
                else if (s == 4'd1)
                begin
                    tick_count = 32'h0;
                    reply_step = 4'd2;
                    queue_rom_run(FIRST_POS, chunk_len);
                end
                else if (s < 4'(DELAY_SLOTS_DEF + 2))
                begin
                    // A timed chunk goes out only once its delay has elapsed.
                    if (tick_count >= slot_delay(s - 2))
                    begin
                        tick_count = 32'h0;
                        reply_step = s + 4'd1;
                        queue_rom_run(s + 1, chunk_len);
                    end
                end
                else
                begin
                    reply_step = 4'd0;
                    rx_state = SEEK_START;
                    if (s == 4'(DELAY_SLOTS_DEF + 2))
                        queue_rom_run(TRAILER_POS, TRAILER_LEN);
                end
            end
        end
    endtask

    // Idle length: mostly short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 3);
        if (r < 9)
            return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    // Drive one request word from a falling edge and wait until it is taken.
    // When typed_n is given, the expected reply is the typed bytes, with the
    // last one closing the chunk; otherwise the predictor supplies it.
    task automatic send_word(input logic func, input logic [7:0] data,
                             input int typed_n = NO_TYPED,
                             input logic [7:0] t0 = 8'h00,
                             input logic [7:0] t1 = 8'h00,
                             input logic [7:0] t2 = 8'h00);
        int gap;
        logic [7:0] typed [3];
        reply_word_t w;
        gap = (src_quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= func;
        req_ch.rx_byte <= data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        track_responder(func, data);
        items_sent++;
        if (typed_n == NO_TYPED)
            foreach (step_words[i])
                pending_reply.push_back(step_words[i]);
        else
        begin
            typed[0] = t0;
            typed[1] = t1;
            typed[2] = t2;
            for (int i = 0; i < typed_n; i++)
            begin
                w.tx_byte = typed[i];
                w.chunk_last = (i == typed_n - 1);
                pending_reply.push_back(w);
            end
        end
        @(negedge clk);
    endtask

    // Send a whole request: start, mark, length, delays, two CRC bytes, end
    // byte. One position may be overwritten with a random byte to break it.
    task automatic send_request_frame(input logic [7:0] clen, input logic [7:0] end_code,
                                      input logic [31:0] dly [DELAY_SLOTS_DEF],
                                      input int corrupt_at);
        logic [7:0] fb [$];
        fb.push_back(START_BYTE);
        fb.push_back(LEN_MARK);
        fb.push_back(clen);
        for (int k = 0; k < DELAY_SLOTS_DEF; k++)
            for (int j = 0; j < 4; j++)
                fb.push_back(dly[k][8 * j +: 8]);
        fb.push_back(8'($urandom));
        fb.push_back(8'($urandom));
        fb.push_back(end_code);
        if (corrupt_at >= 0)
            fb[corrupt_at] = 8'($urandom);
        foreach (fb[i])
            send_word(FUNC_BYTE, fb[i]);
    endtask

    function automatic stim_row_t word_row(input logic func, input logic [7:0] data,
                                           input int n_exp,
                                           input logic [7:0] e0 = 8'h00,
                                           input logic [7:0] e1 = 8'h00,
                                           input logic [7:0] e2 = 8'h00);
        stim_row_t r;
        r.kind = ROW_WORD;
        r.func = func;
        r.data = data;
        r.aux = 8'h00;
        r.count = 0;
        r.n_exp = n_exp;
        r.e0 = e0;
        r.e1 = e1;
        r.e2 = e2;
        return r;
    endfunction

    function automatic stim_row_t frame_row(input logic [7:0] clen, input logic [7:0] end_code,
                                            input int dly);
        stim_row_t r;
        r = word_row(FUNC_BYTE, clen, NO_TYPED);
        r.kind = ROW_FRAME;
        r.aux = end_code;
        r.count = dly;
        return r;
    endfunction

    function automatic stim_row_t tick_row(input int count);
        stim_row_t r;
        r = word_row(FUNC_TICK, 8'h00, NO_TYPED);
        r.kind = ROW_TICKS;
        r.count = count;
        return r;
    endfunction

    // Reply sink: ready goes low for random stretches, with quiet periods in
    // which it stays high so that back-to-back words are taken as well.
    initial
    begin
        rsp_ch.ready = 1'b0;
        sink_quiet = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                sink_quiet = !sink_quiet;
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!sink_quiet && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // Every accepted reply word is checked against the oldest expectation.
    // Values are read at the rising edge, before the block updates them.
    reply_word_t head_word;
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_reply.size() == 0)
            begin
                $error("unexpected reply word: tx_byte=%h chunk_last=%b",
                       rsp_ch.tx_byte, rsp_ch.chunk_last);
                mismatch_count++;
            end
            else
            begin
                head_word = pending_reply.pop_front();
                if (rsp_ch.tx_byte !== head_word.tx_byte)
                begin
                    $error("tx_byte: expected %h, actual %h", head_word.tx_byte, rsp_ch.tx_byte);
                    mismatch_count++;
                end
                if (rsp_ch.chunk_last !== head_word.chunk_last)
                begin
                    $error("chunk_last: expected %b, actual %b",
                           head_word.chunk_last, rsp_ch.chunk_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake or a missing reply word ends here.
    initial
    begin
        #(WATCHDOG_TIME);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [31:0] dly [DELAY_SLOTS_DEF];
        logic [7:0] clen;
        int corrupt_at;
        int guard;
        int r;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_BYTE;
        req_ch.rx_byte = 8'h00;
        mismatch_count = 0;
        items_sent = 0;
        src_quiet = 1'b0;

        rx_state = SEEK_START;
        frame_pos = 0;
        chunk_len = 6'd0;
        reply_step = 4'd0;
        tick_count = 32'h0;
        foreach (frame_mem[i])
            frame_mem[i] = 8'h00;

        // Directed part. Rows with a typed reply are the ones whose outcome is
        // obvious: no reply at all, the header and the trailer.
        // A tick with nothing armed only moves the timer.
        dir_rows.push_back(word_row(FUNC_TICK, 8'h00, 0));
        // Stray bytes at both ends of the range while hunting.
        dir_rows.push_back(word_row(FUNC_BYTE, 8'h00, 0));
        dir_rows.push_back(word_row(FUNC_BYTE, 8'hFF, 0));
        // A wrong mark after the start byte restarts the hunt.
        dir_rows.push_back(word_row(FUNC_BYTE, START_BYTE, 0));
        dir_rows.push_back(word_row(FUNC_BYTE, 8'h2A, 0));
        // A chunk length of zero is rejected.
        dir_rows.push_back(word_row(FUNC_BYTE, START_BYTE, 0));
        dir_rows.push_back(word_row(FUNC_BYTE, LEN_MARK, 0));
        dir_rows.push_back(word_row(FUNC_BYTE, 8'h00, 0));
        // A chunk length one above the largest is rejected too.
        dir_rows.push_back(word_row(FUNC_BYTE, START_BYTE, 0));
        dir_rows.push_back(word_row(FUNC_BYTE, LEN_MARK, 0));
        dir_rows.push_back(word_row(FUNC_BYTE, 8'(MAX_CHUNK_DEF + 1), 0));
        // A full frame closed by a wrong end byte arms nothing.
        dir_rows.push_back(frame_row(8'd1, 8'h00, 0));
        dir_rows.push_back(word_row(FUNC_TICK, 8'hFF, 0));
        // Largest chunk, zero delays: header, eleven chunks, trailer, then idle.
        dir_rows.push_back(frame_row(8'(MAX_CHUNK_DEF), END_BYTE, 0));
        dir_rows.push_back(word_row(FUNC_TICK, 8'h00, 2, START_BYTE, 8'h0D));
        // A start byte during the reply is dropped.
        dir_rows.push_back(word_row(FUNC_BYTE, START_BYTE, 0));
        dir_rows.push_back(tick_row(DELAY_SLOTS_DEF + 1));
        dir_rows.push_back(word_row(FUNC_TICK, 8'h00, 3, 8'h01, 8'h02, END_BYTE));
        dir_rows.push_back(word_row(FUNC_TICK, 8'h00, 0));
        // Smallest chunk with every slot waiting two ticks: some ticks send nothing.
        dir_rows.push_back(frame_row(8'd1, END_BYTE, 2));
        dir_rows.push_back(tick_row(40));
        dir_rows.push_back(word_row(FUNC_BYTE, 8'hFF, 0));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_WORD:
                    send_word(dir_rows[i].func, dir_rows[i].data, dir_rows[i].n_exp,
                              dir_rows[i].e0, dir_rows[i].e1, dir_rows[i].e2);
                ROW_FRAME:
                begin
                    foreach (dly[k])
                        dly[k] = 32'(dir_rows[i].count);
                    send_request_frame(dir_rows[i].data, dir_rows[i].aux, dly, -1);
                end
                default:
                    repeat (dir_rows[i].count)
                        send_word(FUNC_TICK, 8'($urandom));
            endcase
        end

        // Random part. Most rounds send a well-formed frame with random length,
        // short delays and random CRC, then tick it through its whole reply with
        // a few dropped bytes mixed in. Some frames have their start, mark,
        // length or end byte overwritten; the other rounds are plain noise.
        items_sent = 0;
        guard = 0;
        while (items_sent < RANDOM_ITEMS && guard < 100)
        begin
            guard++;
            src_quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r < 8)
            begin
                clen = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 4))
                                                  : 8'($urandom_range(1, MAX_CHUNK_DEF));
                foreach (dly[k])
                    dly[k] = 32'($urandom_range(0, 4));
                corrupt_at = -1;
                if ($urandom_range(0, 5) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: corrupt_at = 0;
                        1: corrupt_at = 1;
                        2: corrupt_at = 2;
                        default: corrupt_at = END_POS;
                    endcase
                end
                send_request_frame(clen, END_BYTE, dly, corrupt_at);
                // Ticks until the trailer went out, or a couple when nothing armed.
                send_word(FUNC_TICK, 8'($urandom));
                send_word(FUNC_TICK, 8'($urandom));
                while (rx_state == REPLYING)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(FUNC_BYTE, 8'($urandom));
                    else
                        send_word(FUNC_TICK, 8'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_word(1'($urandom), 8'($urandom));
            end
        end

        // A last frame with full 32-bit delays. Once a slot waits for a delay
        // that cannot elapse, the reply stays parked there, so it comes last.
        src_quiet = 1'b0;
        foreach (dly[k])
            dly[k] = $urandom;
        dly[0] = 32'($urandom_range(0, 2));
        send_request_frame(8'($urandom_range(1, 4)), END_BYTE, dly, -1);
        repeat (8)
            send_word(FUNC_TICK, 8'($urandom));

        req_ch.valid <= 1'b0;
        while (pending_reply.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/trfr_pkg.sv
rtl/trfr_ifs.sv
rtl/trfr_ctrl.sv
rtl/trfr_dp.sv
rtl/timed_reply_frame_responder_top.sv
dv/tb_timed_reply_frame_responder_top.sv
